// ===== hw/rtl/csem_pkg.sv =====
package csem_pkg;

  localparam int ID_W            = 8;
  localparam int COUNT_W         = 16;
  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int CFG_AW          = 2;
  localparam int CFG_DW          = 32;

  localparam logic [CFG_AW-1:0] REG_INIT_COUNT = CFG_AW'(0);

  localparam logic ACT_WAIT   = 1'b0;
  localparam logic ACT_SIGNAL = 1'b1;

  typedef enum logic [2:0] {
    ST_GRANTED = 3'd0,
    ST_BLOCKED = 3'd1,
    ST_WOKEN   = 3'd2,
    ST_INCR    = 3'd3,
    ST_ERROR   = 3'd4
  } status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } ctrl_state_t;

  typedef struct packed {
    logic load;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } sts_t;

endpackage

// ===== hw/rtl/csem_ctrl.sv =====
module csem_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  csem_pkg::sts_t sts,
  output csem_pkg::cmd_t cmd
);
  import csem_pkg::*;

  ctrl_state_t state_r;
  ctrl_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        if (sts.out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready   = 1'b0;
    cmd.load   = 1'b0;
    cmd.commit = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      S_EXEC: begin
        cmd.commit = sts.out_free;
      end
      default: ;
    endcase
  end

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("ready still high after an item was taken");

  a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> sts.out_free)
    else $error("commit while output register is occupied");

  a_commit_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> in_ready)
    else $error("no return to idle after commit");

  a_cmd_excl: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load, cmd.commit}))
    else $error("load and commit in the same cycle");

endmodule

// ===== hw/rtl/csem_dp.sv =====
module csem_dp #(
  parameter int QUEUE_DEPTH = csem_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  csem_pkg::cmd_t                       cmd,
  output csem_pkg::sts_t                       sts,
  input  logic                                 in_action,
  input  logic [csem_pkg::ID_W-1:0]            in_requester_id,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [2:0]                           out_status,
  output logic [csem_pkg::ID_W-1:0]            out_woken_id,
  output logic [csem_pkg::COUNT_W-1:0]         out_count_now,
  output logic [$clog2(QUEUE_DEPTH+1)-1:0]     out_waiters_now,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [csem_pkg::CFG_AW-1:0]          paddr,
  input  logic [csem_pkg::CFG_DW-1:0]          pwdata,
  output logic [csem_pkg::CFG_DW-1:0]          prdata
);
  import csem_pkg::*;

  localparam int PTR_W  = $clog2(QUEUE_DEPTH);
  localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0]   PTR_LAST  = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [FILL_W-1:0]  FILL_FULL = FILL_W'(QUEUE_DEPTH);
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  logic [ID_W-1:0]    ring [QUEUE_DEPTH];
  logic [ID_W-1:0]    rd_data_r;

  logic               action_r;
  logic [ID_W-1:0]    id_r;
  logic [COUNT_W-1:0] init_r;
  logic [COUNT_W-1:0] count_r, count_nxt;
  logic [PTR_W-1:0]   head_r, head_nxt;
  logic [PTR_W-1:0]   tail_r, tail_nxt;
  logic [FILL_W-1:0]  fill_r, fill_nxt;
  status_t            status_nxt;
  logic [ID_W-1:0]    woken_nxt;
  logic               enq;

  logic               out_valid_r;
  status_t            status_r;
  logic [ID_W-1:0]    woken_r;

  logic               cfg_wr;

  assign cfg_wr = psel && penable && pwrite && (paddr == REG_INIT_COUNT);
  assign prdata = CFG_DW'(init_r);

  assign sts.out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      action_r <= in_action;
      id_r     <= in_requester_id;
    end
  end

  // ring storage, registered read of the oldest waiter
  always_ff @(posedge clk) begin
    if (cmd.commit && enq) begin
      ring[tail_r] <= id_r;
    end
    rd_data_r <= ring[head_r];
  end

  always_comb begin
    count_nxt  = count_r;
    head_nxt   = head_r;
    tail_nxt   = tail_r;
    fill_nxt   = fill_r;
    status_nxt = ST_ERROR;
    woken_nxt  = '0;
    enq        = 1'b0;
    if (action_r == ACT_WAIT) begin
      if (count_r != '0) begin
        count_nxt  = count_r - COUNT_W'(1);
        status_nxt = ST_GRANTED;
      end else if (fill_r != FILL_FULL) begin
        enq        = 1'b1;
        tail_nxt   = (tail_r == PTR_LAST) ? '0 : tail_r + PTR_W'(1);
        fill_nxt   = fill_r + FILL_W'(1);
        status_nxt = ST_BLOCKED;
      end
    end else begin
      if (fill_r != '0) begin
        woken_nxt  = rd_data_r;
        head_nxt   = (head_r == PTR_LAST) ? '0 : head_r + PTR_W'(1);
        fill_nxt   = fill_r - FILL_W'(1);
        status_nxt = ST_WOKEN;
      end else if (count_r != COUNT_MAX) begin
        count_nxt  = count_r + COUNT_W'(1);
        status_nxt = ST_INCR;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      init_r  <= '0;
      count_r <= '0;
      head_r  <= '0;
      tail_r  <= '0;
      fill_r  <= '0;
    end else if (cfg_wr) begin
      init_r  <= pwdata[COUNT_W-1:0];
      count_r <= pwdata[COUNT_W-1:0];
      head_r  <= '0;
      tail_r  <= '0;
      fill_r  <= '0;
    end else if (cmd.commit) begin
      count_r <= count_nxt;
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      fill_r  <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      status_r <= status_nxt;
      woken_r  <= woken_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = status_r;
  assign out_woken_id    = woken_r;
  assign out_count_now   = count_r;
  assign out_waiters_now = fill_r;

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FILL_FULL)
    else $error("waiter count beyond queue depth");

  a_commit_out: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> out_valid_r)
    else $error("result not presented after commit");

  a_cfg_clear: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_wr |=> (fill_r == '0) && (head_r == tail_r))
    else $error("queue not emptied by initial count write");

endmodule

// ===== hw/rtl/counting_semaphore_fifo_waiters_top.sv =====
// channel   direction  handshake              payload
// in_       input      in_valid / in_ready    in_action, in_requester_id
// out_      output     out_valid / out_ready  out_status, out_woken_id,
//                                             out_count_now, out_waiters_now
// cfg       apb write  psel/penable/pwrite    paddr, pwdata, prdata (pready = 1)
//
// each item is accepted, then committed into the output register
// the ring head is read from the waiter memory in the accept cycle, registered
// commit waits while the output register holds an item not yet taken
// synchronous active-low reset: count 0, queue empty, no memory clearing pass
module counting_semaphore_fifo_waiters_top #(
  parameter int QUEUE_DEPTH = csem_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 in_action,
  input  logic [csem_pkg::ID_W-1:0]            in_requester_id,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [2:0]                           out_status,
  output logic [csem_pkg::ID_W-1:0]            out_woken_id,
  output logic [csem_pkg::COUNT_W-1:0]         out_count_now,
  output logic [$clog2(QUEUE_DEPTH+1)-1:0]     out_waiters_now,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [csem_pkg::CFG_AW-1:0]          paddr,
  input  logic [csem_pkg::CFG_DW-1:0]          pwdata,
  output logic [csem_pkg::CFG_DW-1:0]          prdata,
  output logic                                 pready
);
  import csem_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign pready = 1'b1;

  csem_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  csem_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_action       (in_action),
    .in_requester_id (in_requester_id),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_status      (out_status),
    .out_woken_id    (out_woken_id),
    .out_count_now   (out_count_now),
    .out_waiters_now (out_waiters_now),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata)
  );

endmodule

// ===== tb/tb_counting_semaphore_fifo_waiters_top.sv =====
module tb_counting_semaphore_fifo_waiters_top;
  import csem_pkg::*;

  localparam int DEPTH = QUEUE_DEPTH_DEF;
  localparam int FILL_W = $clog2(DEPTH + 1);
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int PHASES = 6;
  localparam int PHASE_ITEMS = 150;

  typedef struct {
    status_t status;
    logic [ID_W-1:0] woken_id;
    logic [COUNT_W-1:0] count_now;
    logic [FILL_W-1:0] waiters_now;
  } sem_result_t;

  class semaphore_scoreboard;
    logic [COUNT_W-1:0] avail;
    logic [ID_W-1:0] waiter_ids[DEPTH];
    int head;
    int tail;
    int fill;
    sem_result_t pending_results[$];
    int errors;

    function new();
      errors = 0;
      reload('0);
    endfunction

    function void reload(logic [COUNT_W-1:0] init_count);
      avail = init_count;
      head = 0;
      tail = 0;
      fill = 0;
    endfunction

    function int pending();
      return pending_results.size();
    endfunction

    function void note_request(logic act, logic [ID_W-1:0] id);
      sem_result_t r;
      r.woken_id = '0;
      if (act == ACT_WAIT) begin
        if (avail != 0) begin
          avail = avail - 1'b1;
          r.status = ST_GRANTED;
        end else if (fill < DEPTH) begin
          waiter_ids[tail] = id;
          tail = (tail + 1) % DEPTH;
          fill++;
          r.status = ST_BLOCKED;
        end else begin
          r.status = ST_ERROR;
        end
      end else begin
        if (fill > 0) begin
          r.woken_id = waiter_ids[head];
          head = (head + 1) % DEPTH;
          fill--;
          r.status = ST_WOKEN;
        end else if (avail == '1) begin
          r.status = ST_ERROR;
        end else begin
          avail = avail + 1'b1;
          r.status = ST_INCR;
        end
      end
      r.count_now = avail;
      r.waiters_now = FILL_W'(fill);
      pending_results.push_back(r);
    endfunction

    function void check_result(logic [2:0] st, logic [ID_W-1:0] woken,
                               logic [COUNT_W-1:0] cnt, logic [FILL_W-1:0] waiters);
      sem_result_t r;
      if (pending_results.size() == 0) begin
        $display("%0t unexpected result status %0d woken_id %0d count_now %0d waiters_now %0d",
                 $time, st, woken, cnt, waiters);
        errors++;
        return;
      end
      r = pending_results.pop_front();
      if (st !== r.status) begin
        $display("%0t status mismatch expected %0d actual %0d", $time, r.status, st);
        errors++;
      end
      if (woken !== r.woken_id) begin
        $display("%0t woken_id mismatch expected %0d actual %0d", $time, r.woken_id, woken);
        errors++;
      end
      if (cnt !== r.count_now) begin
        $display("%0t count_now mismatch expected %0d actual %0d", $time, r.count_now, cnt);
        errors++;
      end
      if (waiters !== r.waiters_now) begin
        $display("%0t waiters_now mismatch expected %0d actual %0d",
                 $time, r.waiters_now, waiters);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  logic in_action;
  logic [ID_W-1:0] in_requester_id;
  logic out_valid;
  logic out_ready;
  logic [2:0] out_status;
  logic [ID_W-1:0] out_woken_id;
  logic [COUNT_W-1:0] out_count_now;
  logic [FILL_W-1:0] out_waiters_now;
  logic psel;
  logic penable;
  logic pwrite;
  logic [CFG_AW-1:0] paddr;
  logic [CFG_DW-1:0] pwdata;
  logic [CFG_DW-1:0] prdata;
  logic pready;

  semaphore_scoreboard sb;
  bit in_idle_on;
  bit out_stall_on;
  int idle_cycles;
  logic [CFG_DW-1:0] phase_init[PHASES];
  int phase_wait_pct[PHASES];

  counting_semaphore_fifo_waiters_top uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_action(in_action),
    .in_requester_id(in_requester_id),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_status(out_status),
    .out_woken_id(out_woken_id),
    .out_count_now(out_count_now),
    .out_waiters_now(out_waiters_now),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    out_ready <= !out_stall_on || ($urandom_range(99) >= 28);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) sb.note_request(in_action, in_requester_id);
      if (out_valid && out_ready)
        sb.check_result(out_status, out_woken_id, out_count_now, out_waiters_now);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || (psel && penable)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t watchdog expired with %0d results outstanding", $time, sb.pending());
        $display("tb_counting_semaphore_fifo_waiters_top: FAIL");
        $finish;
      end
    end
  end

  task automatic push_request(logic act, logic [ID_W-1:0] id);
    int gap;
    in_valid <= 1'b1;
    in_action <= act;
    in_requester_id <= id;
    do @(posedge clk); while (!in_ready);
    gap = 0;
    while (in_idle_on && $urandom_range(99) < 28) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic load_initial_count(logic [CFG_DW-1:0] value);
    drain_results();
    repeat (4) @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= REG_INIT_COUNT;
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    sb.reload(value[COUNT_W-1:0]);
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_action = ACT_WAIT;
    in_requester_id = '0;
    out_ready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    idle_cycles = 0;
    in_idle_on = 1'b1;
    out_stall_on = 1'b1;
    sb = new();
    phase_init[0] = 32'h0000_0000;
    phase_init[1] = 32'h0000_0001;
    phase_init[2] = 32'h0000_FFFF;
    phase_init[3] = 32'h0000_FFFE;
    phase_init[4] = CFG_DW'($urandom_range(65535));
    phase_init[5] = 32'hDEAD_0002;
    phase_wait_pct[0] = 70;
    phase_wait_pct[1] = 50;
    phase_wait_pct[2] = 30;
    phase_wait_pct[3] = 55;
    phase_wait_pct[4] = 50;
    phase_wait_pct[5] = 65;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // count zero: fill the queue, overflow it, wake the two oldest
    push_request(ACT_WAIT, 8'h00);
    push_request(ACT_WAIT, 8'hFF);
    push_request(ACT_WAIT, 8'h55);
    push_request(ACT_WAIT, 8'hAA);
    for (int i = 4; i < DEPTH; i++) push_request(ACT_WAIT, ID_W'(i * 29));
    push_request(ACT_WAIT, 8'h3C);
    push_request(ACT_SIGNAL, 8'hFF);
    push_request(ACT_SIGNAL, 8'h00);

    // reload with waiters queued, then saturate at the top of the count
    load_initial_count(32'h0000_FFFF);
    push_request(ACT_SIGNAL, 8'h12);
    push_request(ACT_WAIT, 8'h81);
    push_request(ACT_SIGNAL, 8'h00);
    push_request(ACT_SIGNAL, 8'hFF);

    load_initial_count(32'h0000_0001);
    push_request(ACT_WAIT, 8'h01);
    push_request(ACT_WAIT, 8'hC3);
    push_request(ACT_SIGNAL, 8'h00);
    push_request(ACT_SIGNAL, 8'h00);

    for (int p = 0; p < PHASES; p++) begin
      load_initial_count(phase_init[p]);
      in_idle_on = (p != 2);
      out_stall_on = (p != 2);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        push_request(($urandom_range(99) < phase_wait_pct[p]) ? ACT_WAIT : ACT_SIGNAL,
                     ID_W'($urandom_range(255)));
      end
    end

    drain_results();
    repeat (10) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb_counting_semaphore_fifo_waiters_top: PASS");
    end else begin
      $display("tb_counting_semaphore_fifo_waiters_top: FAIL");
    end
    $finish;
  end

endmodule
